// File: sv/rtc_pkg.sv
// ----------------------------------------------------------------------------
// rtc_pkg
// Types and constants shared by the resistive touch calibrator.
// ----------------------------------------------------------------------------
package rtc_pkg;

  localparam int unsigned RawW  = 12;
  localparam int unsigned AdcBits = RawW;
  localparam int unsigned PresW = 16;
  localparam int unsigned ScrW  = 9;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROTATION = 3'd0,
    REG_X_MIN    = 3'd1,
    REG_X_MAX    = 3'd2,
    REG_Y_MIN    = 3'd3,
    REG_Y_MAX    = 3'd4,
    REG_P_MIN    = 3'd5,
    REG_P_MAX    = 3'd6,
    REG_PLATE    = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    ROT_PORTRAIT      = 2'd0,
    ROT_LANDSCAPE     = 2'd1,
    ROT_INV_PORTRAIT  = 2'd2,
    ROT_INV_LANDSCAPE = 2'd3
  } rotation_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_MUL   = 2'd1,
    ST_DIV   = 2'd2,
    ST_DONE  = 2'd3
  } back_state_e;

  typedef struct packed {
    logic [RawW-1:0] x_first;
    logic [RawW-1:0] x_second;
    logic [RawW-1:0] y_first;
    logic [RawW-1:0] y_second;
    logic [RawW-1:0] z_one;
    logic [RawW-1:0] z_two;
  } raw_t;

  typedef struct packed {
    logic             touched;
    logic [ScrW-1:0]  screen_x;
    logic [ScrW-1:0]  screen_y;
    logic [PresW-1:0] pressure;
  } result_t;

  typedef struct packed {
    logic [1:0]       rotation;
    logic [RawW-1:0]  x_min;
    logic [RawW-1:0]  x_max;
    logic [RawW-1:0]  y_min;
    logic [RawW-1:0]  y_max;
    logic [PresW-1:0] p_min;
    logic [PresW-1:0] p_max;
    logic [RawW-1:0]  plate;
  } cfg_t;

  // classified item between front and back
  typedef struct packed {
    logic [RawW-1:0] xa;
    logic [RawW-1:0] ya;
    logic [RawW-1:0] z1;
    logic [RawW-1:0] dz;
    logic            p_zero;
    logic [RawW-1:0] xoff;
    logic [RawW-1:0] xspan;
    logic            xempty;
    logic [RawW-1:0] yoff;
    logic [RawW-1:0] yspan;
    logic            yempty;
    logic            xy_in;
  } work_t;

endpackage

// File: sv/rtc_front.sv
// ----------------------------------------------------------------------------
// rtc_front
// Averages raw samples, clamps to windows and classifies pressure cases.
// ----------------------------------------------------------------------------
module rtc_front import rtc_pkg::*; (
  input  raw_t  raw_i,
  input  cfg_t  cfg_i,
  output work_t work_o
);

  logic [RawW:0]   xs, ys;
  logic [RawW-1:0] xa, ya, xc, yc;

  always_comb begin
    xs = {1'b0, raw_i.x_first} + {1'b0, raw_i.x_second};
    ys = {1'b0, raw_i.y_first} + {1'b0, raw_i.y_second};
    xa = xs[RawW:1];
    ya = ys[RawW:1];
    xc = (xa < cfg_i.x_min) ? cfg_i.x_min : ((xa > cfg_i.x_max) ? cfg_i.x_max : xa);
    yc = (ya < cfg_i.y_min) ? cfg_i.y_min : ((ya > cfg_i.y_max) ? cfg_i.y_max : ya);
    work_o.xa     = xa;
    work_o.ya     = ya;
    work_o.z1     = raw_i.z_one;
    work_o.dz     = raw_i.z_two - raw_i.z_one;
    work_o.p_zero = (raw_i.z_one == '0) || (raw_i.z_two < raw_i.z_one);
    work_o.xempty = cfg_i.x_max <= cfg_i.x_min;
    work_o.yempty = cfg_i.y_max <= cfg_i.y_min;
    work_o.xoff   = xc - cfg_i.x_min;
    work_o.yoff   = yc - cfg_i.y_min;
    work_o.xspan  = cfg_i.x_max - cfg_i.x_min;
    work_o.yspan  = cfg_i.y_max - cfg_i.y_min;
    work_o.xy_in  = (xa < cfg_i.x_max) && (xa > cfg_i.x_min) &&
                    (ya < cfg_i.y_max) && (ya > cfg_i.y_min);
  end

endmodule

// File: sv/rtc_fifo.sv
// ----------------------------------------------------------------------------
// rtc_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
module rtc_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == (PtrW+1)'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// File: sv/rtc_back.sv
// ----------------------------------------------------------------------------
// rtc_back
// Multiplies, divides with a shared restoring divider and maps rotation.
// ----------------------------------------------------------------------------
module rtc_back import rtc_pkg::*; #(
  parameter int unsigned PanelLong  = 480,
  parameter int unsigned PanelShort = 320
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    valid_i,
  input  work_t   work_i,
  output logic    take_o,
  output logic    valid_o,
  output result_t result_o,
  input  logic    ready_i
);

  // job 0: pressure, job 1: x scale, job 2: y scale
  localparam int unsigned NumW = 48;
  localparam int unsigned DenW = 26;
  localparam int unsigned CntW = $clog2(NumW + 1);
  localparam int unsigned SpanW = 13;

  back_state_e     state_q, state_d;
  work_t           w_q;
  logic [1:0]      job_q, job_d;
  logic [23:0]     prod_q, prod_d;
  logic [NumW-1:0] num_q, num_d;
  logic [DenW-1:0] den_q, den_d;
  logic [NumW:0]   rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PresW-1:0] p_q, p_d;
  logic [SpanW-1:0] xs_q, xs_d, ys_q, ys_d;
  logic [NumW:0]   rem_sh;
  logic [NumW-1:0] q_d;
  logic [NumW-1:0] quot_q;
  logic            load;
  logic [SpanW-1:0] sx, sy;
  logic            hit;

  assign take_o = (state_q == ST_IDLE) && valid_i;
  assign valid_o = state_q == ST_DONE;

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    prod_d  = prod_q;
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    p_d     = p_q;
    xs_d    = xs_q;
    ys_d    = ys_q;
    load    = 1'b0;
    rem_sh  = '0;
    q_d     = quot_q;
    case (state_q)
      ST_IDLE: begin
        if (valid_i) begin
          state_d = ST_MUL;
          job_d   = 2'd0;
          prod_d  = {12'b0, cfg_i.plate} * {12'b0, work_i.xa};
        end
      end
      ST_MUL: begin
        load  = 1'b1;
        cnt_d = CntW'(NumW);
        rem_d = '0;
        state_d = ST_DIV;
        case (job_q)
          2'd0: begin
            num_d = NumW'({12'b0, prod_q} * {24'b0, w_q.dz});
            den_d = DenW'({w_q.z1, AdcBits'(0)});
          end
          2'd1: begin
            num_d = 48'(w_q.xoff * PanelLong);
            den_d = DenW'(w_q.xspan);
          end
          default: begin
            num_d = 48'(w_q.yoff * PanelShort);
            den_d = DenW'(w_q.yspan);
          end
        endcase
      end
      ST_DIV: begin
        // four restoring steps per cycle
        for (int k = 0; k < 4; k++) begin
          rem_sh = {rem_d[NumW-1:0], num_d[NumW-1]};
          num_d  = {num_d[NumW-2:0], 1'b0};
          q_d    = {q_d[NumW-2:0], 1'b0};
          if (rem_sh >= {{(NumW+1-DenW){1'b0}}, den_q}) begin
            rem_sh = rem_sh - {{(NumW+1-DenW){1'b0}}, den_q};
            q_d[0] = 1'b1;
          end
          rem_d = rem_sh;
        end
        cnt_d = cnt_q - CntW'(4);
        if (cnt_d == '0) begin
          case (job_q)
            2'd0: begin
              p_d = w_q.p_zero ? '0 : ((q_d > NumW'(16'hFFFF)) ? 16'hFFFF : q_d[PresW-1:0]);
              job_d = 2'd1;
              state_d = ST_MUL;
            end
            2'd1: begin
              xs_d = w_q.xempty ? '0 : q_d[SpanW-1:0];
              job_d = 2'd2;
              state_d = ST_MUL;
            end
            default: begin
              ys_d = w_q.yempty ? '0 : q_d[SpanW-1:0];
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_DONE: begin
        if (ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      job_q   <= 2'd0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      w_q <= work_i;
    end
    prod_q <= prod_d;
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    p_q    <= p_d;
    xs_q   <= xs_d;
    ys_q   <= ys_d;
    quot_q <= load ? '0 : q_d;
  end

  always_comb begin
    case (rotation_e'(cfg_i.rotation))
      ROT_LANDSCAPE: begin
        sx = xs_q;
        sy = SpanW'(PanelShort) - ys_q;
      end
      ROT_INV_PORTRAIT: begin
        sx = SpanW'(PanelShort) - ys_q;
        sy = SpanW'(PanelLong) - xs_q;
      end
      ROT_INV_LANDSCAPE: begin
        sx = SpanW'(PanelLong) - xs_q;
        sy = ys_q;
      end
      default: begin
        sx = ys_q;
        sy = xs_q;
      end
    endcase
    hit = w_q.xy_in && (p_q < cfg_i.p_max) && (p_q > cfg_i.p_min);
    result_o.touched  = hit;
    result_o.screen_x = sx[ScrW-1:0];
    result_o.screen_y = sy[ScrW-1:0];
    result_o.pressure = p_q;
  end

endmodule

// File: sv/resistive_touch_calibrator.sv
// each result takes three 48-bit divides in turn on the shared divider, 4 bits a cycle
// the back end takes a new item only once its last result has gone to the output queue
// front end and input queue take new items while the back end works
// output queue holds two results; while it is full the back end stalls, then the input queue fills and push is refused
// reset: asynchronous active low, config registers to defaults, queues empty
// ----------------------------------------------------------------------------
// resistive_touch_calibrator
// Pressure, window check and screen mapping for a four-wire touch panel.
// ----------------------------------------------------------------------------
module resistive_touch_calibrator import rtc_pkg::*; #(
  parameter int unsigned PANEL_LONG  = 480,
  parameter int unsigned PANEL_SHORT = 320
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  raw_t                in_i,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output result_t             out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t    cfg_q;
  work_t   front_w, q_w;
  logic    q_empty, q_full, take;
  logic    b_valid, o_full;
  result_t b_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rotation <= '0;
      cfg_q.x_min    <= '0;
      cfg_q.x_max    <= 12'd4095;
      cfg_q.y_min    <= '0;
      cfg_q.y_max    <= 12'd4095;
      cfg_q.p_min    <= '0;
      cfg_q.p_max    <= 16'hFFFF;
      cfg_q.plate    <= 12'd300;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_ROTATION: cfg_q.rotation <= cfg_data_i[1:0];
        REG_X_MIN:    cfg_q.x_min    <= cfg_data_i[RawW-1:0];
        REG_X_MAX:    cfg_q.x_max    <= cfg_data_i[RawW-1:0];
        REG_Y_MIN:    cfg_q.y_min    <= cfg_data_i[RawW-1:0];
        REG_Y_MAX:    cfg_q.y_max    <= cfg_data_i[RawW-1:0];
        REG_P_MIN:    cfg_q.p_min    <= cfg_data_i;
        REG_P_MAX:    cfg_q.p_max    <= cfg_data_i;
        REG_PLATE:    cfg_q.plate    <= cfg_data_i[RawW-1:0];
        default: ;
      endcase
    end
  end

  rtc_front u_front (.raw_i(in_i), .cfg_i(cfg_q), .work_o(front_w));

  rtc_fifo #(.Width($bits(work_t)), .Depth(2)) u_inq (
    .clk_i, .rst_ni, .push_i(push), .data_i(front_w), .full_o(q_full),
    .pop_i(take), .data_o(q_w), .empty_o(q_empty)
  );
  assign full = q_full;

  rtc_back #(.PanelLong(PANEL_LONG), .PanelShort(PANEL_SHORT)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .valid_i(!q_empty), .work_i(q_w), .take_o(take),
    .valid_o(b_valid), .result_o(b_res), .ready_i(!o_full)
  );

  rtc_fifo #(.Width($bits(result_t)), .Depth(2)) u_outq (
    .clk_i, .rst_ni, .push_i(b_valid), .data_i(b_res), .full_o(o_full),
    .pop_i(pop), .data_o(out_o), .empty_o(empty)
  );

`ifndef SYNTHESIS
  a_take_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> !q_empty) else $error("back end took from empty queue");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid && o_full |=> b_valid) else $error("result dropped");
  a_empty_zero_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_o.touched) |-> out_o.pressure != '0) else $error("touch with zero pressure");
`endif

endmodule
